### hdl/arp_cache_aging_table_defines.svh
// assertion helpers used by arpc_ctrl
`ifndef ARP_CACHE_AGING_TABLE_DEFINES_SVH
`define ARP_CACHE_AGING_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
`define ARPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("arpc assertion failed");
`define ARPC_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("arpc forbidden condition");
`else
`define ARPC_ASSERT(lbl, prop)
`define ARPC_NEVER(lbl, expr)
`endif
`endif

### hdl/arpc_pkg.sv
package arpc_pkg;

    localparam int CACHE_DEPTH = 16;
    localparam int REQ_DEPTH   = 8;
    localparam int CACHE_W     = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int REQ_W       = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;

    localparam logic [2:0] KIND_LOOKUP = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_QUEUE  = 3'd2;
    localparam logic [2:0] KIND_REMOVE = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;

    localparam logic [1:0] EV_REPLY = 2'd0;
    localparam logic [1:0] EV_SEND  = 2'd1;
    localparam logic [1:0] EV_DROP  = 2'd2;

    localparam logic [1:0] REG_TIMEOUT   = 2'd0;
    localparam logic [1:0] REG_MAX_SENDS = 2'd1;

    localparam logic [15:0] TIMEOUT_RST   = 16'd30;
    localparam logic [3:0]  MAX_SENDS_RST = 4'd5;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    typedef struct packed {
        logic exec;
        logic age;
        logic walk;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic walk_last;
    } sts_t;

    function automatic logic [CACHE_W-1:0] first_cache(input logic [CACHE_DEPTH-1:0] v);
        logic [CACHE_W-1:0] r;
        r = '0;
        for (int i = CACHE_DEPTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = CACHE_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [REQ_W-1:0] first_req(input logic [REQ_DEPTH-1:0] v);
        logic [REQ_W-1:0] r;
        r = '0;
        for (int i = REQ_DEPTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = REQ_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### hdl/arpc_ctrl.sv
`include "arp_cache_aging_table_defines.svh"
module arpc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [2:0]      kind,
    output logic            in_stall,
    input  arpc_pkg::sts_t  sts,
    output arpc_pkg::cmd_t  cmd
);
    import arpc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = !((state_reg == ST_IDLE) && sts.out_free);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_TICK))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.out_free && sts.walk_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.exec = accept && (kind != KIND_TICK);
                cmd.age  = accept && (kind == KIND_TICK);
            end
            ST_WALK:
            begin
                cmd.walk = sts.out_free;
            end
            default: cmd = '0;
        endcase
    end

    `ARPC_ASSERT(a_no_accept_in_walk, (state_reg == ST_WALK) |-> in_stall)
    `ARPC_ASSERT(a_age_enters_walk, cmd.age |=> (state_reg == ST_WALK))
    `ARPC_NEVER(a_walk_only_in_walk, cmd.walk && (state_reg != ST_WALK))
    `ARPC_NEVER(a_one_cmd, (cmd.exec && cmd.age) || (cmd.exec && cmd.walk))

endmodule

### hdl/arpc_dpath.sv
module arpc_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  arpc_pkg::cmd_t  cmd,
    output arpc_pkg::sts_t  sts,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data,
    input  logic [2:0]      kind,
    input  logic [31:0]     ip_addr,
    input  logic [47:0]     mac_addr,
    input  logic [3:0]      port_index,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [1:0]      event_res,
    output logic            hit,
    output logic [47:0]     found_mac,
    output logic [31:0]     target_ip,
    output logic [3:0]      out_port,
    output logic            request_pending,
    output logic            new_request,
    output logic            table_full,
    output logic            last
);
    import arpc_pkg::*;

    logic [31:0] entry_ip_reg  [CACHE_DEPTH];
    logic [47:0] entry_mac_reg [CACHE_DEPTH];
    logic [15:0] entry_age_reg [CACHE_DEPTH];
    logic [15:0] entry_age_next[CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] entry_valid_reg, entry_valid_next;
    logic [31:0] pend_ip_reg   [REQ_DEPTH];
    logic [3:0]  pend_port_reg [REQ_DEPTH];
    logic [3:0]  pend_sends_reg [REQ_DEPTH];
    logic [3:0]  pend_sends_next[REQ_DEPTH];
    logic [REQ_DEPTH-1:0] pend_valid_reg, pend_valid_next;
    logic [15:0] timeout_reg;
    logic [3:0]  max_sends_reg;
    logic [REQ_W-1:0] walk_idx_reg, walk_idx_next;
    logic        out_valid_reg, out_valid_next;

    logic [1:0]  ev_reg, ev_next;
    logic        hit_reg, hit_next;
    logic [47:0] mac_reg, mac_next;
    logic [31:0] tip_reg, tip_next;
    logic [3:0]  port_reg, port_next;
    logic        pend_reg, pend_next;
    logic        new_reg, new_next;
    logic        full_reg, full_next;
    logic        last_reg, last_next;
    logic        load;

    // parallel compares
    logic [CACHE_DEPTH-1:0] c_match, c_free;
    logic [REQ_DEPTH-1:0]   p_match, p_free, p_ge, p_gt;
    logic [CACHE_W-1:0]     c_match_idx, c_free_idx;
    logic [REQ_W-1:0]       p_free_idx, walk_slot;
    logic                   ins_do, que_do;

    always_comb
    begin
        for (int i = 0; i < CACHE_DEPTH; i++)
        begin
            c_match[i] = entry_valid_reg[i] && (entry_ip_reg[i] == ip_addr);
            c_free[i]  = !entry_valid_reg[i];
        end
        for (int j = 0; j < REQ_DEPTH; j++)
        begin
            p_match[j] = pend_valid_reg[j] && (pend_ip_reg[j] == ip_addr);
            p_free[j]  = !pend_valid_reg[j];
            p_ge[j]    = pend_valid_reg[j] && (REQ_W'(j) >= walk_idx_reg);
        end
        c_match_idx = first_cache(c_match);
        c_free_idx  = first_cache(c_free);
        p_free_idx  = first_req(p_free);
        walk_slot   = first_req(p_ge);
        for (int j = 0; j < REQ_DEPTH; j++)
        begin
            p_gt[j] = pend_valid_reg[j] && (REQ_W'(j) > walk_slot);
        end
    end

    assign ins_do = cmd.exec && (kind == KIND_INSERT) && (|c_free);
    assign que_do = cmd.exec && (kind == KIND_QUEUE) && !(|p_match) && (|p_free);

    assign sts.out_free  = !out_valid_reg || !out_stall;
    assign sts.walk_last = !(|p_ge) || !(|p_gt);

    always_comb
    begin
        logic [15:0] a_inc;
        entry_valid_next = entry_valid_reg;
        entry_age_next   = entry_age_reg;
        pend_valid_next  = pend_valid_reg;
        pend_sends_next  = pend_sends_reg;
        walk_idx_next    = walk_idx_reg;
        load      = 1'b0;
        ev_next   = EV_REPLY;
        hit_next  = 1'b0;
        mac_next  = '0;
        tip_next  = '0;
        port_next = '0;
        pend_next = 1'b0;
        new_next  = 1'b0;
        full_next = 1'b0;
        last_next = 1'b1;
        a_inc     = '0;

        if (cmd.exec)
        begin
            load = 1'b1;
            case (kind)
                KIND_LOOKUP:
                begin
                    hit_next = |c_match;
                    mac_next = (|c_match) ? entry_mac_reg[c_match_idx] : '0;
                end
                KIND_INSERT:
                begin
                    pend_next = |p_match;
                    full_next = !(|c_free);
                    if (ins_do)
                    begin
                        entry_valid_next[c_free_idx] = 1'b1;
                        entry_age_next[c_free_idx]   = '0;
                    end
                end
                KIND_QUEUE:
                begin
                    if (!(|p_match))
                    begin
                        new_next  = |p_free;
                        full_next = !(|p_free);
                    end
                    if (que_do)
                    begin
                        pend_valid_next[p_free_idx] = 1'b1;
                        pend_sends_next[p_free_idx] = '0;
                    end
                end
                KIND_REMOVE:
                begin
                    pend_valid_next = pend_valid_reg & ~p_match;
                end
                KIND_CLEAR:
                begin
                    entry_valid_next = '0;
                    pend_valid_next  = '0;
                    for (int i = 0; i < CACHE_DEPTH; i++)
                    begin
                        entry_age_next[i] = '0;
                    end
                    for (int j = 0; j < REQ_DEPTH; j++)
                    begin
                        pend_sends_next[j] = '0;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.age)
        begin
            walk_idx_next = '0;
            for (int i = 0; i < CACHE_DEPTH; i++)
            begin
                if (entry_valid_reg[i])
                begin
                    a_inc = (entry_age_reg[i] == 16'hFFFF) ? entry_age_reg[i]
                                                           : entry_age_reg[i] + 16'd1;
                    if (a_inc > timeout_reg)
                    begin
                        entry_valid_next[i] = 1'b0;
                        entry_age_next[i]   = '0;
                    end
                    else
                    begin
                        entry_age_next[i] = a_inc;
                    end
                end
            end
        end

        if (cmd.walk)
        begin
            load      = 1'b1;
            last_next = sts.walk_last;
            if (|p_ge)
            begin
                tip_next  = pend_ip_reg[walk_slot];
                port_next = pend_port_reg[walk_slot];
                if (pend_sends_reg[walk_slot] >= max_sends_reg)
                begin
                    ev_next = EV_DROP;
                    pend_valid_next[walk_slot] = 1'b0;
                end
                else
                begin
                    ev_next = EV_SEND;
                    pend_sends_next[walk_slot] = pend_sends_reg[walk_slot] + 4'd1;
                end
                walk_idx_next = walk_slot + REQ_W'(1);
            end
        end

        out_valid_next = load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            pend_valid_reg  <= '0;
            for (int i = 0; i < CACHE_DEPTH; i++)
            begin
                entry_age_reg[i] <= '0;
            end
            for (int j = 0; j < REQ_DEPTH; j++)
            begin
                pend_sends_reg[j] <= '0;
            end
            timeout_reg   <= TIMEOUT_RST;
            max_sends_reg <= MAX_SENDS_RST;
            walk_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            pend_valid_reg  <= pend_valid_next;
            entry_age_reg   <= entry_age_next;
            pend_sends_reg  <= pend_sends_next;
            walk_idx_reg    <= walk_idx_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TIMEOUT:   timeout_reg   <= cfg_data;
                    REG_MAX_SENDS: max_sends_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_do)
        begin
            entry_ip_reg[c_free_idx]  <= ip_addr;
            entry_mac_reg[c_free_idx] <= mac_addr;
        end
        if (que_do)
        begin
            pend_ip_reg[p_free_idx]   <= ip_addr;
            pend_port_reg[p_free_idx] <= port_index;
        end
        if (load)
        begin
            ev_reg   <= ev_next;
            hit_reg  <= hit_next;
            mac_reg  <= mac_next;
            tip_reg  <= tip_next;
            port_reg <= port_next;
            pend_reg <= pend_next;
            new_reg  <= new_next;
            full_reg <= full_next;
            last_reg <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign event_res       = ev_reg;
    assign hit             = hit_reg;
    assign found_mac       = mac_reg;
    assign target_ip       = tip_reg;
    assign out_port        = port_reg;
    assign request_pending = pend_reg;
    assign new_request     = new_reg;
    assign table_full      = full_reg;
    assign last            = last_reg;

endmodule

### hdl/arp_cache_aging_table.sv
// lookup, insert, queue, remove and clear: one request a cycle unless the output
// stalls, result registered in the cycle after the request is taken
// tick: cache aging in the accept cycle, then one pending-request slot per cycle
// unless the output stalls; requests wait until the walk passes the last pending one
// rst_n async active low: clears valid bits, ages, send counts and config to defaults
module arp_cache_aging_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] ip_addr,
    input  logic [47:0] mac_addr,
    input  logic [3:0]  port_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic        hit,
    output logic [47:0] found_mac,
    output logic [31:0] target_ip,
    output logic [3:0]  out_port,
    output logic        request_pending,
    output logic        new_request,
    output logic        table_full,
    output logic        last
);
    import arpc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    arpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    arpc_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (kind),
        .ip_addr         (ip_addr),
        .mac_addr        (mac_addr),
        .port_index      (port_index),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_res       (event_res),
        .hit             (hit),
        .found_mac       (found_mac),
        .target_ip       (target_ip),
        .out_port        (out_port),
        .request_pending (request_pending),
        .new_request     (new_request),
        .table_full      (table_full),
        .last            (last)
    );

endmodule
